// File: hw/rtl/iaid_pkg.sv
// ----------------------------------------------------------------------------
// iaid_pkg
// Shared types and codes for the indexed array insert/delete block.
// ----------------------------------------------------------------------------
`default_nettype none

package iaid_pkg;

    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int CNT_W   = 5;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND      = 2'd0,
        CMD_INSERT      = 2'd1,
        CMD_REMOVE_LAST = 2'd2,
        CMD_REMOVE_AT   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADIDX = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_FINAL,
        S_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic finish;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic check_ok;
        logic moves_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/iaid_ctrl.sv
// ----------------------------------------------------------------------------
// iaid_ctrl
// Command sequencer: accept, check, shift sweep, final write, result.
// ----------------------------------------------------------------------------
`default_nettype none

module iaid_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  iaid_pkg::dp_stat_t  dp_stat,
    output iaid_pkg::dp_cmd_t   dp_cmd
);
    import iaid_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = dp_stat.check_ok ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                if (dp_stat.moves_done) begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (dp_stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        dp_cmd   = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                dp_cmd.load = s_tvalid;
            end
            S_CHECK: begin
                dp_cmd.start = 1'b1;
            end
            S_SHIFT: begin
                dp_cmd.step = 1'b1;
            end
            S_FINAL: begin
                dp_cmd.finish = 1'b1;
            end
            S_DONE: begin
                dp_cmd.emit = dp_stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/iaid_dp.sv
// ----------------------------------------------------------------------------
// iaid_dp
// Word store, count, range checks, move pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iaid_dp #(
    parameter int DEPTH = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  [iaid_pkg::TDATA_W-1:0] s_tdata,
    input  wire  [iaid_pkg::CMD_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [iaid_pkg::TDATA_W-1:0] m_tdata,
    output logic [iaid_pkg::STAT_W-1:0]  m_tuser,
    input  iaid_pkg::dp_cmd_t            dp_cmd,
    output iaid_pkg::dp_stat_t           dp_stat
);
    import iaid_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    cmd_t             cmd_reg;
    logic [VAL_W-1:0] val_reg;
    logic [POS_W-1:0] pos_reg;
    logic [CW-1:0]    count_reg;
    status_t          status_reg;
    logic [AW-1:0]    at_reg;
    logic [AW-1:0]    rp_reg;
    logic [AW-1:0]    wa_reg;
    logic [CW-1:0]    left_reg;
    logic             pend_reg;
    logic             first_reg;
    logic [VAL_W-1:0] removed_reg;

    logic             m_valid_reg;
    logic [VAL_W-1:0] m_removed_reg;
    status_t          m_status_reg;
    logic [CNT_W-1:0] m_count_reg;

    logic             is_ins;
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    at_x;
    status_t          status_calc;
    logic             rd_en;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [VAL_W-1:0] mem_wd;

    assign is_ins = (cmd_reg == CMD_APPEND) || (cmd_reg == CMD_INSERT);
    assign cnt_x  = XW'(count_reg);

    always_comb begin
        case (cmd_reg)
            CMD_APPEND:      at_x = cnt_x;
            CMD_REMOVE_LAST: at_x = cnt_x - XW'(1);
            default:         at_x = XW'(pos_reg);
        endcase
    end

    // Full is checked before the index; empty before the index on removals.
    always_comb begin
        status_calc = ST_OK;
        if (is_ins) begin
            if (count_reg == CW'(DEPTH)) begin
                status_calc = ST_FULL;
            end else if (at_x > cnt_x) begin
                status_calc = ST_BADIDX;
            end
        end else begin
            if (count_reg == '0) begin
                status_calc = ST_EMPTY;
            end else if (at_x >= cnt_x) begin
                status_calc = ST_BADIDX;
            end
        end
    end

    assign rd_en  = dp_cmd.step && (left_reg != '0);
    assign mem_we = (dp_cmd.step && pend_reg && !(!is_ins && first_reg))
                  || (dp_cmd.finish && is_ins);
    assign mem_wa = dp_cmd.finish ? at_reg : wa_reg;
    assign mem_wd = dp_cmd.finish ? val_reg : rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rdata_reg <= mem[rp_reg];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (dp_cmd.start) begin
                left_reg <= (status_calc == ST_OK) ? CW'(cnt_x - at_x) : '0;
                pend_reg <= 1'b0;
            end else if (dp_cmd.step) begin
                if (rd_en) begin
                    left_reg <= left_reg - CW'(1);
                end
                pend_reg <= rd_en;
            end
            if (dp_cmd.finish) begin
                count_reg <= is_ins ? count_reg + CW'(1) : count_reg - CW'(1);
            end
            if (dp_cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            cmd_reg <= cmd_t'(s_tuser);
            val_reg <= s_tdata[VAL_W-1:0];
            pos_reg <= s_tdata[VAL_W +: POS_W];
        end
        if (dp_cmd.start) begin
            status_reg  <= status_calc;
            at_reg      <= AW'(at_x);
            rp_reg      <= is_ins ? AW'(count_reg - CW'(1)) : AW'(at_x);
            first_reg   <= 1'b1;
            removed_reg <= '0;
        end else if (dp_cmd.step) begin
            if (rd_en) begin
                // Inserts sweep downward, removals upward.
                rp_reg <= is_ins ? rp_reg - AW'(1) : rp_reg + AW'(1);
                wa_reg <= is_ins ? rp_reg + AW'(1) : rp_reg - AW'(1);
            end
            if (pend_reg && !is_ins && first_reg) begin
                removed_reg <= rdata_reg;
                first_reg   <= 1'b0;
            end
        end
        if (dp_cmd.emit) begin
            m_removed_reg <= removed_reg;
            m_status_reg  <= status_reg;
            m_count_reg   <= CNT_W'(count_reg);
        end
    end

    assign dp_stat.check_ok   = (status_calc == ST_OK);
    assign dp_stat.moves_done = (left_reg == '0) && !pend_reg;
    assign dp_stat.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(TDATA_W - VAL_W - CNT_W)'(0), m_count_reg, m_removed_reg};
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

// File: hw/rtl/indexed_array_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_array_insert_delete
// Packed list of up to DEPTH signed words with append, insert at index,
// remove last and remove at index; one result beat per command beat.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata (low bit up)                        tuser
//  s_       in   value[31:0], position[36:32], zero pad    cmd[1:0]
//  m_       out  removed_value[31:0], count[36:32], pad    status[1:0]
//
//  One command at a time. A rejected command goes from the check straight to
//  the result. A successful one first sweeps the words at and above the index
//  (at most DEPTH) through the single read and single write port of the word
//  store, then writes the new word (inserts only) and the count before the result.
//  Reset (aresetn low, synchronous) empties the list at once; the store
//  itself is not cleared. A stalled result waits in the output register.
//
`default_nettype none

module indexed_array_insert_delete #(
    parameter int DEPTH = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [iaid_pkg::TDATA_W-1:0] s_tdata,  // value, position
    input  wire  [iaid_pkg::CMD_W-1:0]   s_tuser,  // cmd
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [iaid_pkg::TDATA_W-1:0] m_tdata,  // removed_value, count
    output logic [iaid_pkg::STAT_W-1:0]  m_tuser   // status
);
    import iaid_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    iaid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    iaid_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

endmodule

`default_nettype wire

// File: hw/rtl/iaid_checker.sv
// ----------------------------------------------------------------------------
// iaid_assertions
// Port-level checks for the indexed array insert/delete block.
// ----------------------------------------------------------------------------
`default_nettype none

module iaid_assertions (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [iaid_pkg::TDATA_W-1:0]  m_tdata,
    input wire [iaid_pkg::STAT_W-1:0]   m_tuser
);
    import iaid_pkg::*;

    // No result is shown right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // Only one command is in flight, so acceptance closes the input side.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in progress");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[VAL_W-1:0] == '0))
        else $error("failed command returned a nonzero word");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[VAL_W +: CNT_W] == '0))
        else $error("empty status with nonzero count");

endmodule

bind indexed_array_insert_delete iaid_assertions u_iaid_assertions (.*);

`default_nettype wire
